// ===== src/ptsch_pkg.sv =====
// Shared types, constants and helpers for the periodic timer scheduler.
// No dependencies; every other file of the block but ptsch_fifo imports this package.
package ptsch_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 16;
  localparam int unsigned TIME_W           = 48;
  localparam int unsigned PER_W            = 32;
  localparam int unsigned CHAN_W           = 4;
  localparam logic [PER_W-1:0] IDLE_WAIT_RESET = PER_W'(1000 * 60);

  // Input operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  // Commands handed from the front end to the engine
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_FIRED = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_ACK   = 2'd2
  } kind_e;

  // Engine sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_SCAN,
    ST_FIRE,
    ST_REPORT
  } eng_state_e;

  typedef struct packed {
    cmd_e              kind;
    logic [CHAN_W-1:0] channel;
    logic [PER_W-1:0]  period;   // already forced to at least one
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    kind_e             kind;
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] wait_time;
    logic              last;
  } res_t;

  // Saturating add of a period onto a time value
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [PER_W-1:0]  b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - PER_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// ===== src/ptsch_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// Depends on nothing; used for the command queue and the result queue.
module ptsch_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  // Advance pointers with explicit wrap
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== src/ptsch_front.sv =====
// Front end: accepts input transactions, classifies them into commands
// and queues them for the engine. Depends on ptsch_pkg and ptsch_fifo.
module ptsch_front #(
  parameter int unsigned NUM_CHANNELS = ptsch_pkg::NUM_CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    op_i,
  input  logic [ptsch_pkg::CHAN_W-1:0]  channel_i,
  input  logic [ptsch_pkg::PER_W-1:0]   period_i,
  input  logic [ptsch_pkg::TIME_W-1:0]  now_i,
  output ptsch_pkg::cmd_t               cmd_o,
  output logic                          cmd_empty_o,
  input  logic                          cmd_pop_i
);
  import ptsch_pkg::*;

  cmd_t cmd_in;
  logic ch_ok;
  logic [$bits(cmd_t)-1:0] cmd_rd;

  // Channels beyond the configured count turn into no-ops
  assign ch_ok = ({3'b000, channel_i} < 7'(NUM_CHANNELS));

  // Classify the incoming transaction
  always_comb begin
    cmd_in.channel = channel_i;
    cmd_in.period  = (period_i == '0) ? PER_W'(1) : period_i;
    cmd_in.now     = now_i;
    case (op_e'(op_i))
      OP_START: cmd_in.kind = ch_ok ? CMD_START : CMD_NOP;
      OP_STOP:  cmd_in.kind = ch_ok ? CMD_STOP : CMD_NOP;
      OP_CHECK: cmd_in.kind = CMD_CHECK;
      default:  cmd_in.kind = CMD_NOP;
    endcase
  end

  ptsch_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_rd),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = cmd_t'(cmd_rd);

endmodule

// ===== src/ptsch_back.sv =====
// Engine: holds the channel table and carries out start, stop and check
// commands, one at a time. Depends on ptsch_pkg.
module ptsch_back #(
  parameter int unsigned NUM_CHANNELS = ptsch_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ptsch_pkg::PER_W-1:0]  cfg_wdata_i,
  input  ptsch_pkg::cmd_t              cmd_i,
  input  logic                         cmd_empty_i,
  output logic                         cmd_pop_o,
  output ptsch_pkg::res_t              res_o,
  output logic                         res_push_o,
  input  logic                         res_full_i
);
  import ptsch_pkg::*;

  localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_CHANNELS + 1);

  typedef struct packed {
    logic [PER_W-1:0]  per;
    logic [TIME_W-1:0] dl;
  } ent_t;

  // Channel table: period and deadline per channel
  ent_t mem [NUM_CHANNELS];

  eng_state_e state_q, state_d;
  cmd_t       cur_q;
  logic [PER_W-1:0]        idle_wait_q;
  logic [NUM_CHANNELS-1:0] pending_q, running_q, handled_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    rvalid_q;
  logic [CH_W-1:0]         ridx_q;
  ent_t                    rd_q;
  logic                    pick_vld_q, min_vld_q;
  logic [CH_W-1:0]         pick_idx_q;
  logic [TIME_W-1:0]       pick_dl_q, min_dl_q;
  logic [PER_W-1:0]        pick_per_q;

  logic            scan_init, scan_done, rd_en;
  logic            take_pick, take_min;
  logic            fire_run, fire_go;
  logic            mem_we;
  logic [CH_W-1:0] mem_waddr, cur_ch;
  ent_t            mem_wdata;
  logic [TIME_W-1:0] wait_val;

  assign cur_ch    = CH_W'(cur_q.channel);
  assign scan_done = (cnt_q == CNT_W'(NUM_CHANNELS)) && !rvalid_q;
  assign rd_en     = (state_q == ST_SCAN) && (cnt_q != CNT_W'(NUM_CHANNELS));
  assign fire_run  = running_q[pick_idx_q];
  assign fire_go   = !fire_run || !res_full_i;

  // Compare stage of the scan: earliest due entry and earliest pending entry
  assign take_min  = rvalid_q && pending_q[ridx_q] && (!min_vld_q || rd_q.dl < min_dl_q);
  assign take_pick = rvalid_q && pending_q[ridx_q] && !handled_q[ridx_q] &&
                     (rd_q.dl <= cur_q.now) && (!pick_vld_q || rd_q.dl < pick_dl_q);

  // Wait until the earliest pending deadline, zero once it is due, idle_wait if none is pending
  always_comb begin
    if (!min_vld_q) begin
      wait_val = {{(TIME_W - PER_W){1'b0}}, idle_wait_q};
    end else if (min_dl_q > cur_q.now) begin
      wait_val = min_dl_q - cur_q.now;
    end else begin
      wait_val = '0;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          state_d = (cmd_i.kind == CMD_CHECK) ? ST_SCAN : ST_ACK;
        end
      end
      ST_ACK: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (scan_done) state_d = pick_vld_q ? ST_FIRE : ST_REPORT;
      end
      ST_FIRE: begin
        if (fire_go) state_d = ST_SCAN;
      end
      ST_REPORT: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and table writes
  always_comb begin
    cmd_pop_o  = 1'b0;
    scan_init  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{kind: KIND_ACK, channel: '0, wait_time: '0, last: 1'b1};
    mem_we     = 1'b0;
    mem_waddr  = cur_ch;
    mem_wdata  = '{per: cur_q.period, dl: sat_add(cur_q.now, cur_q.period)};
    case (state_q)
      ST_IDLE: begin
        cmd_pop_o = !cmd_empty_i;
        scan_init = !cmd_empty_i && (cmd_i.kind == CMD_CHECK);
      end
      ST_ACK: begin
        res_push_o = !res_full_i;
        mem_we     = !res_full_i && (cur_q.kind == CMD_START);
      end
      ST_FIRE: begin
        scan_init  = fire_go;
        res_push_o = fire_run && !res_full_i;
        res_o      = '{kind: KIND_FIRED, channel: CHAN_W'(pick_idx_q),
                       wait_time: '0, last: 1'b0};
        mem_we     = fire_run && !res_full_i;
        mem_waddr  = pick_idx_q;
        mem_wdata  = '{per: pick_per_q, dl: sat_add(pick_dl_q, pick_per_q)};
      end
      ST_REPORT: begin
        res_push_o = !res_full_i;
        res_o      = '{kind: KIND_WAIT, channel: '0, wait_time: wait_val, last: 1'b1};
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idle_wait_q <= IDLE_WAIT_RESET;
      pending_q   <= '0;
      running_q   <= '0;
      handled_q   <= '0;
      cnt_q       <= '0;
      rvalid_q    <= 1'b0;
      pick_vld_q  <= 1'b0;
      min_vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) idle_wait_q <= cfg_wdata_i;
      // Apply start and stop
      if (state_q == ST_ACK && !res_full_i) begin
        if (cur_q.kind == CMD_START) begin
          pending_q[cur_ch] <= 1'b1;
          running_q[cur_ch] <= 1'b1;
        end else if (cur_q.kind == CMD_STOP) begin
          running_q[cur_ch] <= 1'b0;
        end
      end
      // Retire the picked channel; drop it when stopped
      if (state_q == ST_FIRE && fire_go) begin
        handled_q[pick_idx_q] <= 1'b1;
        if (!fire_run) pending_q[pick_idx_q] <= 1'b0;
      end
      if (state_q == ST_IDLE && scan_init) handled_q <= '0;
      // Walk the table
      if (scan_init) begin
        cnt_q      <= '0;
        rvalid_q   <= 1'b0;
        pick_vld_q <= 1'b0;
        min_vld_q  <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        rvalid_q <= rd_en;
        if (rd_en) cnt_q <= cnt_q + 1'b1;
        if (take_pick) pick_vld_q <= 1'b1;
        if (take_min) min_vld_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cur_q <= cmd_i;
    if (state_q == ST_SCAN) ridx_q <= cnt_q[CH_W-1:0];
    if (state_q == ST_SCAN && take_pick) begin
      pick_idx_q <= ridx_q;
      pick_dl_q  <= rd_q.dl;
      pick_per_q <= rd_q.per;
    end
    if (state_q == ST_SCAN && take_min) min_dl_q <= rd_q.dl;
  end

  // Table memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_q <= mem[cnt_q[CH_W-1:0]];
  end

endmodule

// ===== src/periodic_timer_scheduler_top.sv =====
// Periodic timer scheduler, top level: command front end, engine and
// result queue. Depends on ptsch_pkg, ptsch_fifo, ptsch_front, ptsch_back.
//
// Usage
//   Input channel: drive op/channel/period/now and raise push; a transaction
//   is taken at a clock edge with push high and full low. Two commands queue.
//   Result channel: while empty is low the oldest result sits on kind,
//   fired_channel, wait_time, last; pop with pop high takes it. Two results
//   queue; when the receiver stalls the engine holds and the command queue
//   fills, then full rises.
//   Config: cfg_we_i writes cfg_wdata_i into idle_wait at once (reset 60000).
// Operation
//   Start, stop and no-op: one acknowledge each, once the result queue has room.
//   Check: the engine walks the channel table through its single read port,
//   one pass per due channel plus a final pass that reports the wait time.
// Reset
//   All channels idle, queues empty, idle_wait back to 60000. No clearing
//   pass: table entries are used only after a start has written them.
module periodic_timer_scheduler_top #(
  parameter int unsigned NUM_CHANNELS = ptsch_pkg::NUM_CHANNELS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   op_i,
  input  logic [ptsch_pkg::CHAN_W-1:0] channel_i,
  input  logic [ptsch_pkg::PER_W-1:0]  period_i,
  input  logic [ptsch_pkg::TIME_W-1:0] now_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [1:0]                   kind_o,
  output logic [ptsch_pkg::CHAN_W-1:0] fired_channel_o,
  output logic [ptsch_pkg::TIME_W-1:0] wait_time_o,
  output logic                         last_o,
  input  logic                         cfg_we_i,
  input  logic [ptsch_pkg::PER_W-1:0]  cfg_wdata_i
);
  import ptsch_pkg::*;

  cmd_t cmd;
  logic cmd_empty, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;
  logic [$bits(res_t)-1:0] res_rd;

  ptsch_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .channel_i   (channel_i),
    .period_i    (period_i),
    .now_i       (now_i),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty),
    .cmd_pop_i   (cmd_pop)
  );

  ptsch_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Hold results until the receiver pops them
  ptsch_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rd),
    .empty_o (empty)
  );

  assign res_out         = res_t'(res_rd);
  assign kind_o          = res_out.kind;
  assign fired_channel_o = res_out.channel;
  assign wait_time_o     = res_out.wait_time;
  assign last_o          = res_out.last;

endmodule

// ===== src/ptsch_checker.sv =====
// Port-level checks for the periodic timer scheduler, bound to the top.
// Depends on ptsch_pkg.
module ptsch_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         empty,
  input logic                         pop,
  input logic [1:0]                   kind_o,
  input logic [ptsch_pkg::CHAN_W-1:0] fired_channel_o,
  input logic [ptsch_pkg::TIME_W-1:0] wait_time_o,
  input logic                         last_o
);
  import ptsch_pkg::*;

  // No result is offered in the cycle after a reset edge
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result offered after reset");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(fired_channel_o)
                          && $stable(wait_time_o) && $stable(last_o)))
    else $error("waiting result changed");

  // Fired results never close a transaction; reports and acks always do
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((kind_o == KIND_FIRED) == !last_o))
    else $error("last flag does not match result kind");

  // Only a wait report carries a wait time, only a fired result a channel
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((kind_o == KIND_WAIT || wait_time_o == '0) &&
                (kind_o == KIND_FIRED || fired_channel_o == '0) &&
                (kind_o == KIND_FIRED || kind_o == KIND_WAIT || kind_o == KIND_ACK)))
    else $error("result fields inconsistent with kind");

endmodule

bind periodic_timer_scheduler_top ptsch_checker u_ptsch_checker (.*);
